@@ rtl/mstl_pkg.sv @@
// Package for the master/stack tile layout block.
// Holds the slot limits, the payload and control structs and the register indexes.
// No dependencies.
`default_nettype none

package mstl_pkg;

    localparam int WINDOW_SLOTS = 16;
    localparam int MAX_EMIT     = 16;
    localparam int SLOT_LIMIT   = (WINDOW_SLOTS < MAX_EMIT) ? WINDOW_SLOTS : MAX_EMIT;
    localparam int IDX_W        = $clog2(SLOT_LIMIT);
    localparam int CNT_W        = $clog2(SLOT_LIMIT + 1);
    localparam int SLOT_IDX_W   = 4;
    localparam int PIX_W        = 12;
    localparam int BYTE_W       = 8;
    localparam int RATIO_W      = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int DIV_CNT_W    = $clog2(PIX_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH    = 3'd0,
        REG_SCREEN_HEIGHT   = 3'd1,
        REG_TASKBAR_HEIGHT  = 3'd2,
        REG_BORDER_WIDTH    = 3'd3,
        REG_TITLEBAR_HEIGHT = 3'd4,
        REG_MASTER_RATIO    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic active;
        logic tiled;
        logic last_slot;
    } in_t;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [PIX_W-1:0]      pos_x;
        logic [PIX_W-1:0]      pos_y;
        logic [PIX_W-1:0]      width;
        logic [PIX_W-1:0]      height;
        logic [PIX_W-1:0]      content_x;
        logic [PIX_W-1:0]      content_y;
        logic [PIX_W-1:0]      content_width;
        logic [PIX_W-1:0]      content_height;
        logic                  last_rect;
    } out_t;

    typedef struct packed {
        logic record;
        logic prep;
        logic div_step;
        logic scan_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic none_tiled;
        logic need_div;
        logic div_done;
        logic scan_last;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/mstl_dp.sv @@
// Datapath of the master/stack tile layout block: registers, slot map,
// master width multiply, row height divider and rectangle generation.
// Depends on mstl_pkg.
`default_nettype none

module mstl_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mstl_pkg::in_t                   item,
    input  wire logic                            cfg_we,
    input  wire logic [mstl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mstl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire mstl_pkg::ctrl_cmd_t             cmd,
    output mstl_pkg::dp_sts_t                    sts,
    output mstl_pkg::out_t                       result,
    output logic                                 result_strobe
);

    localparam int IDX_W = mstl_pkg::IDX_W;
    localparam int CNT_W = mstl_pkg::CNT_W;
    localparam int PIX_W = mstl_pkg::PIX_W;
    localparam int BW    = mstl_pkg::BYTE_W;
    localparam int RW    = mstl_pkg::RATIO_W;
    localparam int DCW   = mstl_pkg::DIV_CNT_W;

    logic [PIX_W-1:0] screen_w_reg;
    logic [PIX_W-1:0] screen_h_reg;
    logic [PIX_W-1:0] taskbar_h_reg;
    logic [BW-1:0]    border_w_reg;
    logic [BW-1:0]    title_h_reg;
    logic [RW-1:0]    ratio_reg;

    logic             tiled_map_reg [mstl_pkg::SLOT_LIMIT];
    logic [CNT_W-1:0] load_index_reg;
    logic [CNT_W-1:0] tiled_count_reg;

    logic [PIX_W-1:0] col_w_reg;
    logic [PIX_W-1:0] avail_h_reg;
    logic [IDX_W-1:0] divisor_reg;
    logic [PIX_W-1:0] quo_reg;
    logic [IDX_W-1:0] rem_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [IDX_W-1:0] i_reg;
    logic [CNT_W-1:0] k_reg;
    logic [PIX_W-1:0] y_reg;
    mstl_pkg::out_t   result_reg;
    logic             strobe_reg;

    logic [PIX_W+RW-1:0] product;
    logic [PIX_W-1:0]    avail_h;
    logic [IDX_W:0]      trial;
    logic                trial_ge;
    logic                rec_tiled;
    logic                hit;
    logic                single;
    logic                is_last;
    logic [PIX_W-1:0]    stack_w;
    logic [PIX_W-1:0]    rx;
    logic [PIX_W-1:0]    ry;
    logic [PIX_W-1:0]    rw;
    logic [PIX_W-1:0]    rh;
    logic [PIX_W:0]      sum_x;
    logic [PIX_W:0]      sum_y;
    logic [BW:0]         inset_w;
    logic [BW:0]         inset_h;
    mstl_pkg::out_t      rect;

    always_comb
    begin
        product   = PIX_W'(0) + (PIX_W + RW)'(screen_w_reg) * (PIX_W + RW)'(ratio_reg);
        avail_h   = (screen_h_reg > taskbar_h_reg) ? (screen_h_reg - taskbar_h_reg) : '0;
        trial     = {rem_reg, quo_reg[PIX_W-1]};
        trial_ge  = trial >= {1'b0, divisor_reg};
        rec_tiled = item.active && item.tiled;
        hit       = tiled_map_reg[i_reg];
        single    = tiled_count_reg == CNT_W'(1);
        is_last   = (k_reg + CNT_W'(1)) == tiled_count_reg;
        stack_w   = screen_w_reg - col_w_reg;

        if (single)
        begin
            rx = '0;
            ry = '0;
            rw = screen_w_reg;
            rh = avail_h_reg;
        end
        else if (k_reg == '0)
        begin
            rx = '0;
            ry = '0;
            rw = col_w_reg;
            rh = avail_h_reg;
        end
        else
        begin
            rx = col_w_reg;
            ry = y_reg;
            rw = stack_w;
            rh = is_last ? (quo_reg + PIX_W'(rem_reg)) : quo_reg;
        end

        sum_x   = {1'b0, rx} + (PIX_W + 1)'(border_w_reg);
        sum_y   = {1'b0, ry} + (PIX_W + 1)'(title_h_reg);
        inset_w = {border_w_reg, 1'b0};
        inset_h = (BW + 1)'(title_h_reg) + (BW + 1)'(border_w_reg);

        rect.slot_index     = mstl_pkg::SLOT_IDX_W'(i_reg);
        rect.pos_x          = rx;
        rect.pos_y          = ry;
        rect.width          = rw;
        rect.height         = rh;
        rect.content_x      = sum_x[PIX_W] ? '1 : sum_x[PIX_W-1:0];
        rect.content_y      = sum_y[PIX_W] ? '1 : sum_y[PIX_W-1:0];
        rect.content_width  = (rw > PIX_W'(inset_w)) ? (rw - PIX_W'(inset_w)) : '0;
        rect.content_height = (rh > PIX_W'(inset_h)) ? (rh - PIX_W'(inset_h)) : '0;
        rect.last_rect      = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg  <= PIX_W'(1024);
            screen_h_reg  <= PIX_W'(768);
            taskbar_h_reg <= PIX_W'(24);
            border_w_reg  <= BW'(2);
            title_h_reg   <= BW'(20);
            ratio_reg     <= RW'(32768);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mstl_pkg::REG_SCREEN_WIDTH:    screen_w_reg  <= cfg_data[PIX_W-1:0];
                mstl_pkg::REG_SCREEN_HEIGHT:   screen_h_reg  <= cfg_data[PIX_W-1:0];
                mstl_pkg::REG_TASKBAR_HEIGHT:  taskbar_h_reg <= cfg_data[PIX_W-1:0];
                mstl_pkg::REG_BORDER_WIDTH:    border_w_reg  <= cfg_data[BW-1:0];
                mstl_pkg::REG_TITLEBAR_HEIGHT: title_h_reg   <= cfg_data[BW-1:0];
                mstl_pkg::REG_MASTER_RATIO:    ratio_reg     <= cfg_data[RW-1:0];
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg  <= '0;
            tiled_count_reg <= '0;
            div_cnt_reg     <= '0;
            i_reg           <= '0;
            k_reg           <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.scan_step && hit;
            if (cmd.record && (load_index_reg < CNT_W'(mstl_pkg::SLOT_LIMIT)))
            begin
                load_index_reg <= load_index_reg + CNT_W'(1);
                if (rec_tiled)
                begin
                    tiled_count_reg <= tiled_count_reg + CNT_W'(1);
                end
            end
            if (cmd.finish)
            begin
                load_index_reg  <= '0;
                tiled_count_reg <= '0;
            end
            if (cmd.prep)
            begin
                div_cnt_reg <= '0;
                i_reg       <= '0;
                k_reg       <= '0;
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
            if (cmd.scan_step)
            begin
                i_reg <= i_reg + IDX_W'(1);
                if (hit)
                begin
                    k_reg <= k_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.record && (load_index_reg < CNT_W'(mstl_pkg::SLOT_LIMIT)))
        begin
            tiled_map_reg[load_index_reg[IDX_W-1:0]] <= rec_tiled;
        end
        if (cmd.prep)
        begin
            col_w_reg    <= product[PIX_W+RW-1:RW];
            avail_h_reg  <= avail_h;
            divisor_reg  <= IDX_W'(tiled_count_reg - CNT_W'(1));
            quo_reg      <= avail_h;
            rem_reg      <= '0;
            y_reg        <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[PIX_W-2:0], trial_ge};
            rem_reg <= trial_ge ? IDX_W'(trial - {1'b0, divisor_reg}) : IDX_W'(trial);
        end
        if (cmd.scan_step && hit)
        begin
            result_reg <= rect;
            if (!single && (k_reg != '0))
            begin
                y_reg <= y_reg + quo_reg;
            end
        end
    end

    assign sts.none_tiled = tiled_count_reg == '0;
    assign sts.need_div   = tiled_count_reg > CNT_W'(1);
    assign sts.div_done   = div_cnt_reg == DCW'(PIX_W - 1);
    assign sts.scan_last  = (CNT_W'(i_reg) + CNT_W'(1)) == load_index_reg;

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    // A run ends with its final rectangle, so no transaction follows it directly.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && result_reg.last_rect |=> !strobe_reg)
        else $error("transaction followed the final rectangle of a run");

    // The divider only runs with at least one stacked window.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> divisor_reg != '0)
        else $error("division step with zero divisor");

    // The scan never emits more rectangles than tiled slots were recorded.
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step && hit |-> k_reg < tiled_count_reg)
        else $error("more rectangles than tiled slots");

    // The scan only walks slots that were recorded in this run.
    a_scan_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> CNT_W'(i_reg) < load_index_reg)
        else $error("scan beyond the recorded slots");

endmodule

`default_nettype wire

@@ rtl/mstl_ctrl.sv @@
// Controller of the master/stack tile layout block: sequences recording,
// setup, row height division and the slot scan. Depends on mstl_pkg.
`default_nettype none

module mstl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                last_slot,
    input  wire mstl_pkg::dp_sts_t   sts,
    output mstl_pkg::ctrl_cmd_t      cmd,
    output logic                     busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.record = 1'b1;
                    if (last_slot)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                if (sts.none_tiled)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (sts.need_div)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != ST_IDLE;

endmodule

`default_nettype wire

@@ rtl/master_stack_tile_layout.sv @@
// Top level of the master/stack tile layout block.
// Depends on mstl_pkg, mstl_ctrl and mstl_dp.
//
// One transaction on the input side describes one window slot, in slot order
// from slot 0. A transaction is taken at a rising edge where start is high and
// busy is low. Slots that carry no last_slot mark are recorded and busy stays
// low. The slot marked last starts the layout: a setup state with the master
// width multiply, then a bit-serial row height divider when two or more
// windows are tiled, then a scan that visits one recorded slot per cycle.
// Each tiled slot gives one result transaction, shown for one cycle with
// result_strobe high, in the cycle after its scan step; the final one carries
// last_rect. The result of the last recorded slot, if it is tiled, shows in
// the first cycle with busy low. With no tiled slot busy is high in the setup
// state only and nothing is emitted. The receiver cannot stall results.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while busy is low, which the block does not enforce.
// Reset loads the default register values and empties the slot record.
`default_nettype none

module master_stack_tile_layout (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire mstl_pkg::in_t                   item,
    output logic                                 busy,
    input  wire logic                            cfg_we,
    input  wire logic [mstl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mstl_pkg::CFG_DATA_W-1:0] cfg_data,
    output mstl_pkg::out_t                       result,
    output logic                                 result_strobe
);

    mstl_pkg::ctrl_cmd_t cmd;
    mstl_pkg::dp_sts_t   sts;

    mstl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_slot (item.last_slot),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    mstl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

`default_nettype wire
